// ===== rtl/fmdf_pkg.sv =====
// Shared types and constants of the framed message decoder.
package fmdf_pkg;

	localparam logic [7:0] SYNC_FIRST = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;
	localparam logic [15:0] MAX_BODY_LEN_RESET = 16'hFFFF;
	localparam logic REG_MAX_BODY_LEN = 1'b0;

	typedef enum logic [1:0] {
		KIND_BODY = 2'd0,
		KIND_FRAME = 2'd1,
		KIND_PARTIAL = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [7:0] {
		PH_HUNT = 8'b0000_0001,
		PH_SYNC2 = 8'b0000_0010,
		PH_CLASS = 8'b0000_0100,
		PH_ID = 8'b0000_1000,
		PH_LEN_LO = 8'b0001_0000,
		PH_LEN_HI = 8'b0010_0000,
		PH_BODY = 8'b0100_0000,
		PH_CK_B = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data_out;
		logic [7:0] msg_class;
		logic [7:0] msg_id;
		logic [15:0] body_length;
		logic last;
	} res_t;

	// Up to two results caused by one accepted byte.
	typedef struct packed {
		logic [1:0] cnt;
		res_t r0;
		res_t r1;
	} push_t;

endpackage

// ===== rtl/framed_message_decoder_fletcher.sv =====
// Framed message decoder: hunts for sync 0xB5 0x62 frames, checks the
// Fletcher-8 sum and streams body bytes and frame status. One received
// byte is taken per clock cycle; its results land in a queue of
// QUEUE_DEPTH entries (a power of two, at least 4), and a byte is taken
// only while two entries are free. The output drains one result per
// cycle while m_tready is high, so a byte that gives two results (a body
// byte that also ends the buffer) needs two output transfers; otherwise
// the sustained rate is one byte per cycle.
module framed_message_decoder_fletcher #(
	parameter int QUEUE_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [7:0] data_in
	input logic s_tlast, // end_of_buffer
	output logic m_tvalid,
	input logic m_tready,
	// [7:0] data_out, [15:8] msg_class, [23:16] msg_id, [39:24] body_length
	output logic [39:0] m_tdata,
	output logic [1:0] m_tuser, // [1:0] kind
	output logic m_tlast, // last
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import fmdf_pkg::*;

	logic [15:0] max_len_q;
	logic accept;
	push_t push;
	res_t out_res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_BODY_LEN) ? {16'd0, max_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_BODY_LEN_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_MAX_BODY_LEN) begin
			max_len_q <= pwdata[15:0];
		end
	end

	assign accept = s_tvalid & s_tready;

	fmdf_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.data_in(s_tdata),
		.end_of_buffer(s_tlast),
		.max_body_length(max_len_q),
		.push(push)
	);

	fmdf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.space_ok(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(out_res)
	);

	assign m_tdata = {out_res.body_length, out_res.msg_id, out_res.msg_class,
		out_res.data_out};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

// ===== rtl/fmdf_parser.sv =====
// Frame hunting state machine with Fletcher-8 check and result generation.
module fmdf_parser (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] data_in,
	input logic end_of_buffer,
	input logic [15:0] max_body_length,
	output fmdf_pkg::push_t push
);
	import fmdf_pkg::*;

	phase_t phase_q, phase_d;
	logic [7:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
	logic [15:0] exp_len_q, exp_len_d, body_cnt_q, body_cnt_d;
	logic [7:0] class_q, class_d, id_q, id_d;
	logic [7:0] add_base_a, add_base_b, add_a;
	logic do_add, body_out, complete;
	res_t body_res, frame_res, status_res;

	// Class restarts the checksum, so the accumulators start from zero there.
	assign add_base_a = (phase_q == PH_CLASS) ? 8'd0 : sum_a_q;
	assign add_base_b = (phase_q == PH_CLASS) ? 8'd0 : sum_b_q;
	assign add_a = add_base_a + data_in;

	always_comb begin
		phase_d = phase_q;
		exp_len_d = exp_len_q;
		body_cnt_d = body_cnt_q;
		class_d = class_q;
		id_d = id_q;
		do_add = 1'b0;
		body_out = 1'b0;
		complete = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				if (data_in == SYNC_FIRST) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase_d = (data_in == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
			end
			PH_CLASS: begin
				class_d = data_in;
				do_add = 1'b1;
				phase_d = PH_ID;
			end
			PH_ID: begin
				id_d = data_in;
				do_add = 1'b1;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				exp_len_d = {8'd0, data_in};
				do_add = 1'b1;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				exp_len_d = {data_in, exp_len_q[7:0]};
				body_cnt_d = 16'd0;
				do_add = 1'b1;
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				if (body_cnt_q < exp_len_q) begin
					body_out = (body_cnt_q < max_body_length);
					do_add = 1'b1;
					body_cnt_d = body_cnt_q + 16'd1;
				end else begin
					phase_d = (data_in == sum_a_q) ? PH_CK_B : PH_HUNT;
				end
			end
			PH_CK_B: begin
				complete = (data_in == sum_b_q);
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		sum_a_d = do_add ? add_a : sum_a_q;
		sum_b_d = do_add ? add_base_b + add_a : sum_b_q;
	end

	always_comb begin
		body_res = '{KIND_BODY, data_in, class_q, id_q, 16'd0, ~end_of_buffer};
		frame_res = '{KIND_FRAME, 8'd0, class_q, id_q, body_cnt_q, 1'b1};
		if (phase_d != PH_HUNT) begin
			status_res = '{KIND_PARTIAL, 8'd0, class_d, id_d, 16'd0, 1'b1};
		end else begin
			status_res = '{KIND_NONE, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1};
		end
		push.r0 = status_res;
		push.r1 = status_res;
		push.cnt = 2'd0;
		if (accept) begin
			priority if (body_out) begin
				push.r0 = body_res;
				push.cnt = end_of_buffer ? 2'd2 : 2'd1;
			end else if (complete) begin
				push.r0 = frame_res;
				push.cnt = 2'd1;
			end else if (end_of_buffer) begin
				push.cnt = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_a_q <= 8'd0;
			sum_b_q <= 8'd0;
			exp_len_q <= 16'd0;
			body_cnt_q <= 16'd0;
			class_q <= 8'd0;
			id_q <= 8'd0;
		end else if (accept) begin
			if (end_of_buffer) begin
				phase_q <= PH_HUNT;
				sum_a_q <= 8'd0;
				sum_b_q <= 8'd0;
				exp_len_q <= 16'd0;
				body_cnt_q <= 16'd0;
				class_q <= 8'd0;
				id_q <= 8'd0;
			end else begin
				phase_q <= phase_d;
				sum_a_q <= sum_a_d;
				sum_b_q <= sum_b_d;
				exp_len_q <= exp_len_d;
				body_cnt_q <= body_cnt_d;
				class_q <= class_d;
				id_q <= id_d;
			end
		end
	end

endmodule

// ===== rtl/fmdf_queue.sv =====
// Result queue that takes up to two results per cycle and gives one.
module fmdf_queue #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input fmdf_pkg::push_t push,
	output logic space_ok,
	output logic out_valid,
	input logic out_ready,
	output fmdf_pkg::res_t out_res
);
	import fmdf_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	res_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic pop;

	assign out_valid = (cnt_q != '0);
	assign out_res = mem_q[rd_ptr_q];
	assign pop = out_valid & out_ready;
	// A request is taken only while two entries are free.
	assign space_ok = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push.cnt == 2'd2) mem_q[wr_ptr_q + PW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.cnt);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			cnt_q <= cnt_q + CW'(push.cnt) - CW'(pop);
		end
	end

endmodule

// ===== rtl/fmdf_checker.sv =====
// Port-level assertions for the framed message decoder, bound to the top level.
module fmdf_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic m_tlast
);
	import fmdf_pkg::*;

	// A stalled result keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// Frame and buffer status results always close the results of their byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_BODY |-> m_tlast)
		else $error("status result without last");

	// Only a completed frame carries a body length.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_FRAME |-> m_tdata[39:24] == 16'd0)
		else $error("body length outside a frame result");

	// Nothing found means no frame fields at all.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_NONE |-> m_tdata == 40'd0)
		else $error("not-found result with data");

endmodule

bind framed_message_decoder_fletcher fmdf_checker u_fmdf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tlast(m_tlast)
);
